### design/rwcp_pkg.sv
// Package for the RIFF WAVE chunk parser: phase and result codes,
// chunk ids and the result record passed from the parse core to the top level.
// No dependencies.
package rwcp_pkg;

  // input item kinds
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_EOS  = 1'b1;

  // result kinds
  localparam logic [2:0] RES_PAYLOAD  = 3'd0;
  localparam logic [2:0] RES_FORMAT   = 3'd1;
  localparam logic [2:0] RES_NOT_RIFF = 3'd2;
  localparam logic [2:0] RES_NOT_WAVE = 3'd3;
  localparam logic [2:0] RES_NOT_PCM  = 3'd4;

  // little-endian four-character codes
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [15:0] CODE_PCM = 16'd1;

  // parser phases
  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_HDR  = 3'd1,
    PH_FMT  = 3'd2,
    PH_DATA = 3'd3,
    PH_SKIP = 3'd4,
    PH_IDLE = 3'd5
  } phase_t;

  // one result item as produced by the core
  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [7:0]  pbyte;
    logic        last;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
  } result_t;

endpackage

### design/riff_wave_chunk_parser.sv
// Top level of the RIFF WAVE chunk parser: input register, parse core and
// result register with stream handshakes. Uses rwcp_pkg and rwcp_core.
//
// channel  | direction | tdata                       | tuser          | tlast
// ---------+-----------+-----------------------------+----------------+-------------
// s_*      | in        | data_byte                   | kind           | -
// m_*      | out       | byte, channels, rate, bits  | result_kind    | payload_last
//
// One item is accepted per cycle while the output does not stall; a result is offered from the
// result register once its item has passed from the input register through the parse step.
// The rate is set by the combinational parse step between input and result register.
// rst (synchronous) empties both registers and returns the parser to the RIFF header.
// A stalled result holds; the input register keeps one item while the output stalls.
module riff_wave_chunk_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [7:0] payload_byte, [23:8] channel_count,
                                 // [55:24] rate_hz, [71:56] sample_bits
  output logic [2:0]  m_tuser,   // [2:0] result_kind
  output logic        m_tlast    // payload_last
);

  logic              in_valid;
  logic              in_kind;
  logic [7:0]        in_byte;
  logic              proceed;
  rwcp_pkg::result_t res;
  rwcp_pkg::result_t out_reg;

  assign proceed  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || proceed;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proceed) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  rwcp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (proceed),
    .kind      (in_kind),
    .data_byte (in_byte),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proceed) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) out_reg <= res;
  end

  assign m_tdata = {out_reg.bits, out_reg.rate, out_reg.channels, out_reg.pbyte};
  assign m_tuser = out_reg.kind;
  assign m_tlast = out_reg.last;

endmodule

### design/rwcp_core.sv
// Parse core of the RIFF WAVE chunk parser: phase machine, byte counter and
// chunk/fmt field registers; advances one item per step. Uses rwcp_pkg.
module rwcp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              kind,
  input  logic [7:0]        data_byte,
  output rwcp_pkg::result_t res
);

  rwcp_pkg::phase_t phase, phase_next;
  logic [31:0] byte_offset, byte_offset_next;
  logic [31:0] chunk_id_reg, chunk_length;
  logic [15:0] format_code, channels_reg, bits_reg;
  logic [31:0] rate_reg;

  logic [31:0] offset_inc;
  logic [1:0]  lane;
  logic [31:0] id_new, len_new;
  logic [15:0] code_new, ch_new, bits_new;
  logic [31:0] rate_new;
  logic        eos, last_byte, riff_done, hdr_done, fmt_start, zero_off;

  assign eos        = (kind == rwcp_pkg::IN_EOS);
  assign offset_inc = byte_offset + 32'd1;
  assign lane       = byte_offset[1:0];
  // last body byte: offset == length - 1, modulo 2^32
  assign last_byte  = (offset_inc == chunk_length);
  assign riff_done  = (phase == rwcp_pkg::PH_RIFF) && (byte_offset >= 32'd11);
  assign hdr_done   = (phase == rwcp_pkg::PH_HDR) && (byte_offset >= 32'd7);
  assign fmt_start  = hdr_done && (chunk_id_reg == rwcp_pkg::ID_FMT);

  // byte lane merge into the word and fmt fields being assembled
  always_comb begin
    id_new   = chunk_id_reg;
    len_new  = chunk_length;
    code_new = format_code;
    ch_new   = channels_reg;
    rate_new = rate_reg;
    bits_new = bits_reg;
    case (phase)
      rwcp_pkg::PH_RIFF: begin
        if (byte_offset >= 32'd4 && byte_offset < 32'd8) begin
          len_new[{lane, 3'b000} +: 8] = data_byte;
        end else begin
          id_new[{lane, 3'b000} +: 8] = data_byte;
        end
      end
      rwcp_pkg::PH_HDR: begin
        if (byte_offset < 32'd4) begin
          id_new[{lane, 3'b000} +: 8] = data_byte;
        end else begin
          len_new[{lane, 3'b000} +: 8] = data_byte;
        end
      end
      rwcp_pkg::PH_FMT: begin
        if (byte_offset < 32'd2) begin
          code_new[{lane[0], 3'b000} +: 8] = data_byte;
        end else if (byte_offset < 32'd4) begin
          ch_new[{lane[0], 3'b000} +: 8] = data_byte;
        end else if (byte_offset < 32'd8) begin
          rate_new[{lane, 3'b000} +: 8] = data_byte;
        end else if (byte_offset >= 32'd14 && byte_offset < 32'd16) begin
          bits_new[{lane[0], 3'b000} +: 8] = data_byte;
        end
      end
      default: begin
      end
    endcase
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (eos) begin
      phase_next = rwcp_pkg::PH_RIFF;
    end else begin
      unique case (phase)
        rwcp_pkg::PH_RIFF: begin
          if (byte_offset == 32'd3 && id_new != rwcp_pkg::ID_RIFF) begin
            phase_next = rwcp_pkg::PH_IDLE;
          end else if (riff_done) begin
            phase_next = (id_new != rwcp_pkg::ID_WAVE) ? rwcp_pkg::PH_IDLE
                                                        : rwcp_pkg::PH_HDR;
          end
        end
        rwcp_pkg::PH_HDR: begin
          if (hdr_done) begin
            if (chunk_id_reg == rwcp_pkg::ID_FMT) begin
              phase_next = (len_new == 32'd0) ? rwcp_pkg::PH_IDLE : rwcp_pkg::PH_FMT;
            end else if (len_new == 32'd0) begin
              phase_next = rwcp_pkg::PH_HDR;
            end else if (chunk_id_reg == rwcp_pkg::ID_DATA) begin
              phase_next = rwcp_pkg::PH_DATA;
            end else begin
              phase_next = rwcp_pkg::PH_SKIP;
            end
          end
        end
        rwcp_pkg::PH_FMT: begin
          if (last_byte) begin
            phase_next = (code_new != rwcp_pkg::CODE_PCM) ? rwcp_pkg::PH_IDLE
                                                           : rwcp_pkg::PH_HDR;
          end
        end
        rwcp_pkg::PH_DATA, rwcp_pkg::PH_SKIP: begin
          if (last_byte) phase_next = rwcp_pkg::PH_HDR;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // result of this step
  always_comb begin
    res = '0;
    if (!eos) begin
      unique case (phase)
        rwcp_pkg::PH_RIFF: begin
          if (byte_offset == 32'd3 && id_new != rwcp_pkg::ID_RIFF) begin
            res.valid = 1'b1;
            res.kind  = rwcp_pkg::RES_NOT_RIFF;
          end else if (riff_done && id_new != rwcp_pkg::ID_WAVE) begin
            res.valid = 1'b1;
            res.kind  = rwcp_pkg::RES_NOT_WAVE;
          end
        end
        rwcp_pkg::PH_HDR: begin
          // empty fmt chunk has a zero format code
          if (fmt_start && len_new == 32'd0) begin
            res.valid = 1'b1;
            res.kind  = rwcp_pkg::RES_NOT_PCM;
          end
        end
        rwcp_pkg::PH_FMT: begin
          if (last_byte) begin
            res.valid = 1'b1;
            if (code_new != rwcp_pkg::CODE_PCM) begin
              res.kind = rwcp_pkg::RES_NOT_PCM;
            end else begin
              res.kind     = rwcp_pkg::RES_FORMAT;
              res.channels = ch_new;
              res.rate     = rate_new;
              res.bits     = bits_new;
            end
          end
        end
        rwcp_pkg::PH_DATA: begin
          res.valid = 1'b1;
          res.kind  = rwcp_pkg::RES_PAYLOAD;
          res.pbyte = data_byte;
          res.last  = last_byte;
        end
        default: begin
        end
      endcase
    end
  end

  // byte counter: restarts at every header or body boundary and at end of stream
  assign zero_off = eos || riff_done || hdr_done ||
                    (last_byte && (phase == rwcp_pkg::PH_FMT ||
                                   phase == rwcp_pkg::PH_DATA ||
                                   phase == rwcp_pkg::PH_SKIP));
  assign byte_offset_next = zero_off ? 32'd0 : offset_inc;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rwcp_pkg::PH_RIFF;
      byte_offset <= '0;
    end else if (step) begin
      phase <= phase_next;
      if (eos || phase != rwcp_pkg::PH_IDLE) byte_offset <= byte_offset_next;
    end
  end

  // field registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_id_reg <= '0;
      chunk_length <= '0;
      format_code  <= '0;
      channels_reg <= '0;
      rate_reg     <= '0;
      bits_reg     <= '0;
    end else if (step) begin
      if (eos) begin
        chunk_id_reg <= '0;
        chunk_length <= '0;
        format_code  <= '0;
        channels_reg <= '0;
        rate_reg     <= '0;
        bits_reg     <= '0;
      end else begin
        chunk_id_reg <= id_new;
        chunk_length <= len_new;
        if (fmt_start) begin
          format_code  <= '0;
          channels_reg <= '0;
          rate_reg     <= '0;
          bits_reg     <= '0;
        end else begin
          format_code  <= code_new;
          channels_reg <= ch_new;
          rate_reg     <= rate_new;
          bits_reg     <= bits_new;
        end
      end
    end
  end

endmodule

### design/rwcp_checker.sv
// Port-level checks for riff_wave_chunk_parser, bound to the top level.
// Uses rwcp_pkg for result codes.
module rwcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its contents
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

  // only payload items mark the chunk end
  a_last_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == rwcp_pkg::RES_PAYLOAD)
    else $error("last mark on a non-payload item");

  // format fields are zero except on a format item
  a_fmt_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != rwcp_pkg::RES_FORMAT |-> m_tdata[71:8] == 64'd0)
    else $error("format fields set on a non-format item");

  // result codes stay within the defined set
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= rwcp_pkg::RES_NOT_PCM)
    else $error("undefined result kind");

endmodule

bind riff_wave_chunk_parser rwcp_checker u_rwcp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### tb/riff_wave_chunk_parser_tb.sv
`timescale 1ns / 1ps
// Testbench for riff_wave_chunk_parser: streams RIFF WAVE files, broken headers and noise
// and checks every result item against a built-in parser model. Uses rwcp_pkg.
module riff_wave_chunk_parser_tb;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 400;

  // one input item, or a marker that makes the sender wait for all results
  typedef struct {
    logic       kind;
    logic [7:0] data;
    bit         drain;
  } stream_item_t;

  // one expected result item
  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  pbyte;
    logic        plast;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
  } wave_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
  logic        s_tuser = 1'b0;   // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;          // [7:0] payload_byte, [23:8] channel_count,
                                 // [55:24] rate_hz, [71:56] sample_bits
  logic [2:0]  m_tuser;          // [2:0] result_kind
  logic        m_tlast;          // payload_last

  stream_item_t stim_q[$];
  wave_result_t wave_results_q[$];
  int           stim_total   = 0;
  int           inputs_taken = 0;
  int           err_count    = 0;
  int           cycle_count  = 0;
  bit           in_fire      = 1'b0;
  bit           quiet        = 1'b0;
  int           tx_gap       = 0;
  int           rx_gap       = 0;
  bit           hold_done    = 1'b0;

  // parser model state
  rwcp_pkg::phase_t parse_phase;
  logic [31:0] byte_pos, shift_pos, chunk_id, chunk_len;
  logic [31:0] fmt_code, fmt_chans, fmt_rate, fmt_bits;

  riff_wave_chunk_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- parser model

  task automatic reset_parser();
    parse_phase = rwcp_pkg::PH_RIFF;
    byte_pos  = 0;
    shift_pos = 0;
    chunk_id  = 0;
    chunk_len = 0;
    fmt_code  = 0;
    fmt_chans = 0;
    fmt_rate  = 0;
    fmt_bits  = 0;
  endtask

  task automatic emit(input logic [2:0] k, input logic [7:0] pb, input logic pl,
                      input logic [15:0] ch, input logic [31:0] rt, input logic [15:0] bt);
    wave_result_t r;
    r.kind  = k;
    r.pbyte = pb;
    r.plast = pl;
    r.chans = ch;
    r.rate  = rt;
    r.bits  = bt;
    wave_results_q.push_back(r);
  endtask

  task automatic step_pos();
    byte_pos  = byte_pos + 1;
    shift_pos = (shift_pos + 8) & 32'd31;
  endtask

  task automatic next_header();
    parse_phase = rwcp_pkg::PH_HDR;
    byte_pos    = 0;
    shift_pos   = 0;
  endtask

  // end of a fmt body: report the format or reject a non-pcm code
  task automatic finish_fmt();
    next_header();
    if (fmt_code[15:0] != rwcp_pkg::CODE_PCM) begin
      parse_phase = rwcp_pkg::PH_IDLE;
      emit(rwcp_pkg::RES_NOT_PCM, 8'd0, 1'b0, 16'd0, 32'd0, 16'd0);
    end else begin
      emit(rwcp_pkg::RES_FORMAT, 8'd0, 1'b0, fmt_chans[15:0], fmt_rate, fmt_bits[15:0]);
    end
  endtask

  task automatic parse_step(input logic kind, input logic [7:0] b);
    logic [31:0] bw;
    logic [31:0] sh;
    logic [31:0] sh16;
    logic        at_end;
    bw   = {24'd0, b};
    sh   = shift_pos & 32'd31;
    sh16 = shift_pos & 32'd8;
    if (kind == rwcp_pkg::IN_EOS) begin
      reset_parser();
    end else begin
      case (parse_phase)
        // file header: id, size, form type
        rwcp_pkg::PH_RIFF: begin
          if (byte_pos >= 4 && byte_pos < 8) begin
            if (sh == 0) chunk_len = 0;
            chunk_len = chunk_len | (bw << sh);
          end else begin
            if (sh == 0) chunk_id = 0;
            chunk_id = chunk_id | (bw << sh);
          end
          if (byte_pos == 3 && chunk_id != rwcp_pkg::ID_RIFF) begin
            parse_phase = rwcp_pkg::PH_IDLE;
            emit(rwcp_pkg::RES_NOT_RIFF, 8'd0, 1'b0, 16'd0, 32'd0, 16'd0);
          end else if (byte_pos >= 11) begin
            if (chunk_id != rwcp_pkg::ID_WAVE) begin
              parse_phase = rwcp_pkg::PH_IDLE;
              emit(rwcp_pkg::RES_NOT_WAVE, 8'd0, 1'b0, 16'd0, 32'd0, 16'd0);
            end else begin
              next_header();
            end
          end else begin
            step_pos();
          end
        end
        // chunk header: id then size, then pick the body handling
        rwcp_pkg::PH_HDR: begin
          if (byte_pos < 4) begin
            if (sh == 0) chunk_id = 0;
            chunk_id = chunk_id | (bw << sh);
          end else begin
            if (sh == 0) chunk_len = 0;
            chunk_len = chunk_len | (bw << sh);
          end
          if (byte_pos >= 7) begin
            byte_pos  = 0;
            shift_pos = 0;
            if (chunk_id == rwcp_pkg::ID_FMT) begin
              fmt_code    = 0;
              fmt_chans   = 0;
              fmt_rate    = 0;
              fmt_bits    = 0;
              parse_phase = rwcp_pkg::PH_FMT;
              if (chunk_len == 0) finish_fmt();
            end else begin
              parse_phase = (chunk_id == rwcp_pkg::ID_DATA) ? rwcp_pkg::PH_DATA
                                                            : rwcp_pkg::PH_SKIP;
              if (chunk_len == 0) next_header();
            end
          end else begin
            step_pos();
          end
        end
        // fmt body: code, channels, rate, bits at offset 14
        rwcp_pkg::PH_FMT: begin
          if (byte_pos < 2)
            fmt_code = fmt_code | (bw << sh16);
          else if (byte_pos < 4)
            fmt_chans = fmt_chans | (bw << sh16);
          else if (byte_pos < 8)
            fmt_rate = fmt_rate | (bw << sh);
          else if (byte_pos >= 14 && byte_pos < 16)
            fmt_bits = fmt_bits | (bw << sh16);
          if (byte_pos == chunk_len - 32'd1) finish_fmt();
          else step_pos();
        end
        rwcp_pkg::PH_DATA: begin
          at_end = (byte_pos == chunk_len - 32'd1);
          emit(rwcp_pkg::RES_PAYLOAD, b, at_end, 16'd0, 32'd0, 16'd0);
          if (at_end) next_header();
          else step_pos();
        end
        rwcp_pkg::PH_SKIP: begin
          if (byte_pos == chunk_len - 32'd1) next_header();
          else step_pos();
        end
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------- stimulus builders

  task automatic add_item(input logic kind, input logic [7:0] data);
    stream_item_t it;
    it.kind  = kind;
    it.data  = data;
    it.drain = 1'b0;
    stim_q.push_back(it);
    stim_total++;
  endtask

  task automatic add_drain();
    stream_item_t it;
    it.kind  = rwcp_pkg::IN_BYTE;
    it.data  = 8'd0;
    it.drain = 1'b1;
    stim_q.push_back(it);
  endtask

  task automatic add_eos();
    add_item(rwcp_pkg::IN_EOS, 8'($urandom));
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_item(rwcp_pkg::IN_BYTE, w[8*i +: 8]);
  endtask

  task automatic add_header(input logic [31:0] riff_id, input logic [31:0] form_id);
    add_word(riff_id);
    add_word($urandom);
    add_word(form_id);
  endtask

  // chunk with random body bytes
  task automatic add_chunk(input logic [31:0] id, input int len);
    add_word(id);
    add_word(len);
    repeat (len) add_item(rwcp_pkg::IN_BYTE, 8'($urandom));
  endtask

  // fmt chunk cut or padded to len bytes
  task automatic add_fmt(input logic [15:0] code, input logic [15:0] ch,
                         input logic [31:0] rate, input logic [15:0] bits, input int len);
    logic [7:0] body[$];
    logic [31:0] extra;
    extra = $urandom;
    body = {code[7:0], code[15:8], ch[7:0], ch[15:8],
            rate[7:0], rate[15:8], rate[23:16], rate[31:24],
            8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
            extra[7:0], extra[15:8], bits[7:0], bits[15:8]};
    while (body.size() < len) body.push_back(8'($urandom));
    add_word(rwcp_pkg::ID_FMT);
    add_word(len);
    for (int i = 0; i < len; i++) add_item(rwcp_pkg::IN_BYTE, body[i]);
  endtask

  task automatic add_random_file();
    int pick;
    int n;
    int c;
    pick = $urandom_range(0, 99);
    // plain noise, with the odd end of stream
    if (pick < 5) begin
      n = $urandom_range(1, 20);
      repeat (n)
        add_item(($urandom_range(0, 15) == 0) ? rwcp_pkg::IN_EOS : rwcp_pkg::IN_BYTE,
                 8'($urandom));
      return;
    end
    // broken file headers, trailing bytes are ignored
    if (pick < 12) begin
      if (pick < 8)
        add_header(rwcp_pkg::ID_RIFF ^ (32'd1 << $urandom_range(0, 31)), rwcp_pkg::ID_WAVE);
      else
        add_header(rwcp_pkg::ID_RIFF, rwcp_pkg::ID_WAVE ^ (32'd1 << $urandom_range(0, 31)));
      n = $urandom_range(0, 3);
      repeat (n) add_item(rwcp_pkg::IN_BYTE, 8'($urandom));
      add_eos();
      return;
    end
    // well-formed file with random chunks
    add_header(rwcp_pkg::ID_RIFF, rwcp_pkg::ID_WAVE);
    n = $urandom_range(1, 4);
    repeat (n) begin
      c = $urandom_range(0, 9);
      if (c < 4)
        add_fmt(($urandom_range(0, 7) == 0) ? 16'($urandom) : rwcp_pkg::CODE_PCM,
                16'($urandom), $urandom, 16'($urandom),
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 24) : 16);
      else if (c < 8)
        add_chunk(rwcp_pkg::ID_DATA, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64)
                                                                 : $urandom_range(0, 16));
      else
        add_chunk($urandom, $urandom_range(0, 12));
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) add_item(rwcp_pkg::IN_BYTE, 8'($urandom));
      add_eos();
    end else if (pick != 1) begin
      add_eos();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_parser();

    // restart at reset, then a bad file id with an ignored byte
    add_eos();
    add_word(32'h5846_4952);
    add_item(rwcp_pkg::IN_BYTE, 8'hFF);
    add_eos();
    // zero-length fmt chunk reports not pcm at once
    add_header(rwcp_pkg::ID_RIFF, rwcp_pkg::ID_WAVE);
    add_fmt(rwcp_pkg::CODE_PCM, 16'd1, 32'd1, 16'd1, 0);
    add_item(rwcp_pkg::IN_BYTE, 8'h00);
    add_eos();
    // bad form type
    add_header(rwcp_pkg::ID_RIFF, rwcp_pkg::ID_WAVE ^ 32'h8000_0000);
    add_eos();
    // extremes, empty chunks, long and short fmt, one-byte data, non-pcm code
    add_header(rwcp_pkg::ID_RIFF, rwcp_pkg::ID_WAVE);
    add_fmt(rwcp_pkg::CODE_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16);
    add_chunk(rwcp_pkg::ID_DATA, 0);
    add_chunk(32'hFFFF_FFFF, 0);
    add_chunk(rwcp_pkg::ID_DATA, 3);
    add_fmt(rwcp_pkg::CODE_PCM, 16'd0, 32'd0, 16'd0, 20);
    add_fmt(rwcp_pkg::CODE_PCM, 16'd2, 32'd48000, 16'd16, 6);
    add_chunk(rwcp_pkg::ID_DATA, 1);
    add_fmt(16'hFFFE, 16'd2, 32'd44100, 16'd24, 16);
    add_item(rwcp_pkg::IN_BYTE, 8'h55);
    add_eos();
    add_drain();

    // random files, with a full drain after each file that ends within 40 items past halfway
    begin
      int base;
      base = stim_total;
      while (stim_total - base < RANDOM_ITEMS) begin
        add_random_file();
        if (!hold_done && stim_total - base >= RANDOM_ITEMS / 2 &&
            stim_total - base < RANDOM_ITEMS / 2 + 40)
          add_drain();
      end
    end

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    while (inputs_taken != stim_total || wave_results_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin : drive
    stream_item_t it;
    logic go;
    go = 1'b0;
    if (!rst && (!s_tvalid || in_fire)) begin
      // a drain marker holds the sender until all results are in
      if (stim_q.size() != 0 && stim_q[0].drain && wave_results_q.size() == 0)
        stim_q.delete(0);
      if (tx_gap != 0) begin
        tx_gap--;
      end else if (stim_q.size() != 0 && !stim_q[0].drain) begin
        if (!quiet && $urandom_range(0, 15) == 0) begin
          tx_gap = $urandom_range(0, 10);
        end else begin
          it = stim_q.pop_front();
          go = 1'b1;
        end
      end
      s_tvalid <= go;
      if (go) begin
        s_tdata <= it.data;
        s_tuser <= it.kind;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    // one long stall while the sender keeps offering items
    if (!hold_done && inputs_taken >= HOLD_AT) begin
      rx_gap    = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (rx_gap != 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      rx_gap = $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    wave_result_t want;
    in_fire = !rst && s_tvalid && s_tready;
    quiet   = stim_q.size() < QUIET_TAIL;
    // predict from the accepted input item
    if (in_fire) begin
      inputs_taken++;
      parse_step(s_tuser, s_tdata);
    end
    // compare the accepted result item with the oldest prediction
    if (!rst && m_tvalid && m_tready) begin
      if (wave_results_q.size() == 0) begin
        $error("result item with none expected: result_kind %0d", m_tuser);
        err_count++;
      end else begin
        want = wave_results_q.pop_front();
        check_field("result_kind", want.kind, m_tuser);
        check_field("payload_byte", want.pbyte, m_tdata[7:0]);
        check_field("payload_last", want.plast, m_tlast);
        check_field("channel_count", want.chans, m_tdata[23:8]);
        check_field("rate_hz", want.rate, m_tdata[55:24]);
        check_field("sample_bits", want.bits, m_tdata[71:56]);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

### files.f
design/rwcp_pkg.sv
design/rwcp_core.sv
design/riff_wave_chunk_parser.sv
design/rwcp_checker.sv
tb/riff_wave_chunk_parser_tb.sv
